// ===== src/vector_normalize_eps_snap_unit_defines.svh =====
// Assertion macros for the vector normalize unit.
// Used by the top level; define ASSERT_OFF to drop all checks.
`ifndef VECTOR_NORMALIZE_EPS_SNAP_UNIT_DEFINES_SVH
`define VECTOR_NORMALIZE_EPS_SNAP_UNIT_DEFINES_SVH
`ifndef ASSERT_OFF
// clocked check, disabled while reset is low
`define VNES_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
// clocked check, active during reset too
`define VNES_ASSERT_ALWAYS(lbl, clk, prop, msg) \
    lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define VNES_ASSERT(lbl, clk, rst_n, prop, msg)
`define VNES_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

// ===== src/vnes_pkg.sv =====
// Shared constants for the vector normalize unit.
// No dependencies; imported by every module of the block.
package vnes_pkg;
    localparam int FRAC_BITS_DEF   = 16;
    localparam int COORD_WIDTH_DEF = 32;
    localparam int EPS_W           = 16;
    localparam int LEN_W           = 32;
    localparam logic [EPS_W-1:0] EPS_RESET = 16'd7;
endpackage

// ===== src/vnes_sqrt.sv =====
// Pipelined integer square root, one result bit per stage.
// Depends on vnes_pkg.
module vnes_sqrt import vnes_pkg::*; #(
    parameter int W = COORD_WIDTH_DEF
) (
    input  logic           i_clk,
    input  logic           i_en,
    input  logic [2*W-1:0] i_sum,
    output logic [W-1:0]   o_root
);
    logic [2*W-1:0] r_rem  [W];
    logic [W-1:0]   r_root [W];
    logic [2*W-1:0] n_rem  [W];
    logic [W-1:0]   n_root [W];

    // try one root bit per stage against the running remainder
    always_comb begin
        logic [2*W-1:0] s_rem;
        logic [W-1:0]   s_root;
        logic [2*W:0]   trial;
        for (int k = 0; k < W; k++) begin
            s_rem  = (k == 0) ? i_sum : r_rem[(k == 0) ? 0 : k-1];
            s_root = (k == 0) ? '0    : r_root[(k == 0) ? 0 : k-1];
            trial  = ((2*W+1)'(s_root) << (W - k)) | ((2*W+1)'(1) << (2*(W-1-k)));
            if (trial <= {1'b0, s_rem}) begin
                n_rem[k]          = s_rem - trial[2*W-1:0];
                n_root[k]         = s_root;
                n_root[k][W-1-k]  = 1'b1;
            end else begin
                n_rem[k]  = s_rem;
                n_root[k] = s_root;
            end
        end
    end

    // advance all stages together
    always_ff @(posedge i_clk) begin
        if (i_en) begin
            for (int k = 0; k < W; k++) begin
                r_rem[k]  <= n_rem[k];
                r_root[k] <= n_root[k];
            end
        end
    end

    assign o_root = r_root[W-1];
endmodule

// ===== src/vnes_lane.sv =====
// One component lane: magnitude and square, delay to the root, then
// fractional divide, clamp, snap and sign. Depends on vnes_pkg.
module vnes_lane import vnes_pkg::*; #(
    parameter int W   = COORD_WIDTH_DEF,
    parameter int F   = FRAC_BITS_DEF,
    parameter int DLY = COORD_WIDTH_DEF + 2
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_vec,
    input  logic [EPS_W-1:0]    i_eps,
    input  logic [W-1:0]        i_len,
    input  logic                i_degen,
    output logic [2*W-1:0]      o_sq,
    output logic signed [F+1:0] o_unit
);
    localparam int MW = (W > F + 1) ? W : F + 1;
    localparam int CW = (F + 1 > EPS_W) ? F + 1 : EPS_W;
    localparam logic [F:0] ONE = (F+1)'(1) << F;

    logic [W-1:0]   n_mag;
    logic [2*W-1:0] n_sq;
    logic [W-1:0]   r_mag;
    logic           r_neg;
    logic [2*W-1:0] r_sq;
    logic [W-1:0]   r_mag_dly [DLY];
    logic           r_neg_dly [DLY];

    logic [W-1:0] r_rem [F+1];
    logic [F:0]   r_q   [F+1];
    logic [W-1:0] r_den [F+1];
    logic [F:0]   r_dq  [F+1];
    logic         r_dg  [F+1];
    logic         r_ng  [F+1];
    logic [W-1:0] n_rem [F+1];
    logic [F:0]   n_q   [F+1];
    logic [F:0]   n_dq0;
    logic [F:0]   n_sel;
    logic [F:0]   n_cl;
    logic [F:0]   n_sn;
    logic signed [F+1:0] r_unit;

    // magnitude of the component and its square
    assign n_mag = i_vec[W-1] ? (~$unsigned(i_vec) + 1'b1) : $unsigned(i_vec);
    assign n_sq  = n_mag * n_mag;

    // divide: integer bit first, then one fraction bit per stage
    always_comb begin
        logic [W:0] sh;
        logic [W-1:0] dm;
        dm = r_mag_dly[DLY-1];
        if (dm >= i_len) begin
            n_rem[0] = dm - i_len;
            n_q[0]   = (F+1)'(1);
        end else begin
            n_rem[0] = dm;
            n_q[0]   = '0;
        end
        n_dq0 = (MW'(dm) > MW'(ONE)) ? ONE : (F+1)'(dm);
        for (int k = 1; k <= F; k++) begin
            sh = {r_rem[k-1], 1'b0};
            if (sh >= {1'b0, r_den[k-1]}) begin
                n_rem[k] = W'(sh - {1'b0, r_den[k-1]});
                n_q[k]   = {r_q[k-1][F-1:0], 1'b1};
            end else begin
                n_rem[k] = sh[W-1:0];
                n_q[k]   = {r_q[k-1][F-1:0], 1'b0};
            end
        end
    end

    // select, clamp to one, snap small values, apply sign
    assign n_sel = r_dg[F] ? r_dq[F] : r_q[F];
    assign n_cl  = (n_sel > ONE) ? ONE : n_sel;
    assign n_sn  = (CW'(n_cl) < CW'(i_eps)) ? '0 : n_cl;

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_mag <= n_mag;
            r_neg <= i_vec[W-1];
            r_sq  <= n_sq;
            r_mag_dly[0] <= r_mag;
            r_neg_dly[0] <= r_neg;
            for (int j = 1; j < DLY; j++) begin
                r_mag_dly[j] <= r_mag_dly[j-1];
                r_neg_dly[j] <= r_neg_dly[j-1];
            end
            r_rem[0] <= n_rem[0];
            r_q[0]   <= n_q[0];
            r_den[0] <= i_len;
            r_dq[0]  <= n_dq0;
            r_dg[0]  <= i_degen;
            r_ng[0]  <= r_neg_dly[DLY-1];
            for (int k = 1; k <= F; k++) begin
                r_rem[k] <= n_rem[k];
                r_q[k]   <= n_q[k];
                r_den[k] <= r_den[k-1];
                r_dq[k]  <= r_dq[k-1];
                r_dg[k]  <= r_dg[k-1];
                r_ng[k]  <= r_ng[k-1];
            end
            r_unit <= r_ng[F] ? -$signed({1'b0, n_sn}) : $signed({1'b0, n_sn});
        end
    end

    assign o_sq   = r_sq;
    assign o_unit = r_unit;
endmodule

// ===== src/vector_normalize_eps_snap_unit.sv =====
// Top level of the vector normalize unit: three lanes, sum, root, merge.
// Depends on vnes_pkg, vnes_lane, vnes_sqrt and the defines header.
//
//  channel  | signals                               | dir
//  input    | i_valid o_ready i_vec_x/y/z           | in
//  result   | o_valid i_ready o_unit_x/y/z o_length  | out
//           | o_degenerate                          |
//  config   | i_cfg_valid o_cfg_ready i_cfg_epsilon | in
//
// One word accepted per cycle while the output is not stalled; COORD_WIDTH +
// FRAC_BITS + 5 register stages, set by the bit-per-stage root and the
// bit-per-stage divide in each lane.
// Reset clears the stage valid bits and loads epsilon with 7.
// A stalled output holds the whole pipeline; ready falls only then.
// Config writes are taken every cycle.
`include "vector_normalize_eps_snap_unit_defines.svh"
module vector_normalize_eps_snap_unit import vnes_pkg::*; #(
    parameter int FRAC_BITS   = FRAC_BITS_DEF,
    parameter int COORD_WIDTH = COORD_WIDTH_DEF
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [COORD_WIDTH-1:0] i_vec_x,
    input  logic signed [COORD_WIDTH-1:0] i_vec_y,
    input  logic signed [COORD_WIDTH-1:0] i_vec_z,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [FRAC_BITS+1:0]   o_unit_x,
    output logic signed [FRAC_BITS+1:0]   o_unit_y,
    output logic signed [FRAC_BITS+1:0]   o_unit_z,
    output logic [LEN_W-1:0]              o_length,
    output logic                          o_degenerate,
    input  logic                          i_cfg_valid,
    output logic                          o_cfg_ready,
    input  logic [EPS_W-1:0]              i_cfg_epsilon
);
    localparam int W     = COORD_WIDTH;
    localparam int F     = FRAC_BITS;
    localparam int DEPTH = W + F + 5;
    localparam int LW    = (W > LEN_W) ? W : LEN_W;
    localparam int OD    = F + 2;
    localparam logic signed [F+1:0] UNIT_MAX = (F+2)'(1) << F;
    localparam logic signed [F+1:0] UNIT_MIN = -UNIT_MAX;

    logic             en;
    logic [DEPTH-1:0] r_vld;
    logic [EPS_W-1:0] r_eps;
    logic [2*W-1:0]   sq_x, sq_y, sq_z;
    logic [2*W-1:0]   r_sum;
    logic [W-1:0]     root;
    logic [W-1:0]     r_len;
    logic             r_degen;
    logic [LEN_W-1:0] r_len_out;
    logic [LW-1:0]    len_ext;
    logic [LEN_W-1:0] r_lo_dly [OD];
    logic             r_dg_dly [OD];

    // advance when the output word is empty or being taken
    assign en          = !r_vld[DEPTH-1] || i_ready;
    assign o_ready     = en;
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
            r_eps <= EPS_RESET;
        end else begin
            if (en) r_vld <= {r_vld[DEPTH-2:0], i_valid};
            if (i_cfg_valid) r_eps <= i_cfg_epsilon;
        end
    end

    vnes_lane #(.W(W), .F(F), .DLY(W + 2)) u_lane_x (
        .i_clk(i_clk), .i_en(en), .i_vec(i_vec_x), .i_eps(r_eps),
        .i_len(r_len), .i_degen(r_degen), .o_sq(sq_x), .o_unit(o_unit_x)
    );
    vnes_lane #(.W(W), .F(F), .DLY(W + 2)) u_lane_y (
        .i_clk(i_clk), .i_en(en), .i_vec(i_vec_y), .i_eps(r_eps),
        .i_len(r_len), .i_degen(r_degen), .o_sq(sq_y), .o_unit(o_unit_y)
    );
    vnes_lane #(.W(W), .F(F), .DLY(W + 2)) u_lane_z (
        .i_clk(i_clk), .i_en(en), .i_vec(i_vec_z), .i_eps(r_eps),
        .i_len(r_len), .i_degen(r_degen), .o_sq(sq_z), .o_unit(o_unit_z)
    );

    vnes_sqrt #(.W(W)) u_sqrt (
        .i_clk(i_clk), .i_en(en), .i_sum(r_sum), .o_root(root)
    );

    // merge the lanes, decide degenerate, saturate length for output
    assign len_ext = LW'(root);

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_sum     <= sq_x + sq_y + sq_z;
            r_len     <= root;
            r_degen   <= (LW'(root) <= LW'(r_eps));
            r_len_out <= (|(len_ext >> LEN_W)) ? '1 : len_ext[LEN_W-1:0];
            r_lo_dly[0] <= r_len_out;
            r_dg_dly[0] <= r_degen;
            for (int j = 1; j < OD; j++) begin
                r_lo_dly[j] <= r_lo_dly[j-1];
                r_dg_dly[j] <= r_dg_dly[j-1];
            end
        end
    end

    assign o_valid      = r_vld[DEPTH-1];
    assign o_length     = r_lo_dly[OD-1];
    assign o_degenerate = r_dg_dly[OD-1];

    `VNES_ASSERT(a_hold_on_stall, i_clk, i_rst_n, !en |=> $stable(r_vld), "pipeline moved while stalled")
    `VNES_ASSERT(a_len_nonzero, i_clk, i_rst_n, (o_valid && !o_degenerate) |-> (o_length != '0), "non-degenerate result with zero length")
    `VNES_ASSERT(a_unit_range, i_clk, i_rst_n, o_valid |-> (o_unit_x <= UNIT_MAX && o_unit_x >= UNIT_MIN), "unit x out of range")
    `VNES_ASSERT_ALWAYS(a_rst_empty, i_clk, !i_rst_n |=> !o_valid, "output valid after reset")
endmodule
